// ----- rtl/cbs_pkg.sv -----
`default_nettype none

package cbs_pkg;

    // Field and register widths
    localparam int PW    = 32;
    localparam int SW    = 17;
    localparam int CFGW  = 25;
    localparam int INV2W = 34;

    // Basis combinations
    localparam int A0W   = 35;
    localparam int A1W   = 33;
    localparam int A2W   = 34;
    localparam int A3W   = 35;
    localparam int A1X3W = 35;
    localparam int A2X3W = 36;

    // Partial products against s, s^2, s^3 (s taken as an 18-bit signed operand)
    localparam int T1W = A1X3W + SW + 1;
    localparam int T2W = A2X3W + SW + 1;
    localparam int V1W = A2W + SW + 1;
    localparam int V2W = A3W + SW + 1;
    localparam int WW  = A3W + SW + 1;
    localparam int P3W = A3W + SW + 1;

    // Polynomial sums and rounded derivative magnitudes
    localparam int SUMW = 54;
    localparam int MAGW = 35;

    // Output scaling
    localparam int UW   = 33;
    localparam int PQW  = 31;
    localparam int QW   = 53;
    localparam int VPW  = MAGW + CFGW;
    localparam int APW  = MAGW + INV2W;

    // Register stages from input to output register
    localparam int LAT = 7;

    localparam logic [SW-1:0]    ONE_Q16  = 17'd65536;
    localparam logic [CFGW-1:0]  INV_RST  = 25'd65536;
    localparam logic [INV2W-1:0] INV2_RST = 34'd65536;

    // Per-stage advance enables, stage 1 in the LSB
    typedef struct packed {
        logic s7;
        logic s6;
        logic s5;
        logic s4;
        logic s3;
        logic s2;
        logic s1;
    } t_adv;

endpackage

`default_nettype wire

// ----- rtl/cbs_basis.sv -----
`default_nettype none

module cbs_basis (
    input  logic                              i_clk,
    input  cbs_pkg::t_adv                     i_adv,
    input  logic signed [cbs_pkg::PW-1:0]     i_ctrl_p0,
    input  logic signed [cbs_pkg::PW-1:0]     i_ctrl_p1,
    input  logic signed [cbs_pkg::PW-1:0]     i_ctrl_p2,
    input  logic signed [cbs_pkg::PW-1:0]     i_ctrl_p3,
    input  logic        [cbs_pkg::SW-1:0]     i_param_s,
    output logic signed [cbs_pkg::A0W-1:0]    o_c0,
    output logic signed [cbs_pkg::A1W-1:0]    o_c1,
    output logic signed [cbs_pkg::A2W-1:0]    o_c2,
    output logic signed [cbs_pkg::A3W-1:0]    o_c3,
    output logic        [cbs_pkg::SW-1:0]     o_s3,
    output logic signed [cbs_pkg::T1W-1:0]    o_t1,
    output logic signed [cbs_pkg::T2W-1:0]    o_t2,
    output logic signed [cbs_pkg::V1W-1:0]    o_v1,
    output logic signed [cbs_pkg::V2W-1:0]    o_v2,
    output logic signed [cbs_pkg::WW-1:0]     o_w
);
    import cbs_pkg::*;

    // stage 1: basis combinations, clamped s, s^2
    logic signed [A0W-1:0]   n_a0;
    logic signed [A1W-1:0]   n_a1;
    logic signed [A2W-1:0]   n_a2;
    logic signed [A3W-1:0]   n_a3;
    logic signed [A3W-1:0]   n_d12;
    logic signed [A1X3W-1:0] n_a1x3;
    logic signed [A2X3W-1:0] n_a2x3;
    logic        [SW-1:0]    n_s;
    logic        [2*SW-1:0]  n_ssq;
    logic        [2*SW-1:0]  n_ssq_rnd;

    logic signed [A0W-1:0]   r_a0;
    logic signed [A1W-1:0]   r_a1;
    logic signed [A2W-1:0]   r_a2;
    logic signed [A3W-1:0]   r_a3;
    logic signed [A1X3W-1:0] r_a1x3;
    logic signed [A2X3W-1:0] r_a2x3;
    logic        [SW-1:0]    r_s;
    logic        [SW-1:0]    r_s2;

    assign n_a0   = A0W'(i_ctrl_p0) + (A0W'(i_ctrl_p1) <<< 2) + A0W'(i_ctrl_p2);
    assign n_a1   = A1W'(i_ctrl_p2) - A1W'(i_ctrl_p0);
    assign n_a2   = A2W'(i_ctrl_p0) - (A2W'(i_ctrl_p1) <<< 1) + A2W'(i_ctrl_p2);
    assign n_d12  = A3W'(i_ctrl_p1) - A3W'(i_ctrl_p2);
    assign n_a3   = A3W'(i_ctrl_p3) - A3W'(i_ctrl_p0) + (n_d12 <<< 1) + n_d12;
    assign n_a1x3 = (A1X3W'(n_a1) <<< 1) + A1X3W'(n_a1);
    assign n_a2x3 = (A2X3W'(n_a2) <<< 1) + A2X3W'(n_a2);

    // s beyond one sticks at one
    assign n_s       = (i_param_s > ONE_Q16) ? ONE_Q16 : i_param_s;
    assign n_ssq     = n_s * n_s;
    assign n_ssq_rnd = n_ssq + (2*SW)'(32768);

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_a0   <= n_a0;
            r_a1   <= n_a1;
            r_a2   <= n_a2;
            r_a3   <= n_a3;
            r_a1x3 <= n_a1x3;
            r_a2x3 <= n_a2x3;
            r_s    <= n_s;
            r_s2   <= n_ssq_rnd[SW+15:16];
        end
    end

    // stage 2: s^3 and the products against s and s^2
    logic signed [SW:0]     s_sx;
    logic signed [SW:0]     s2_sx;
    logic        [2*SW-1:0] n_scb;
    logic        [2*SW-1:0] n_scb_rnd;
    logic signed [T1W-1:0]  n_t1;
    logic signed [T2W-1:0]  n_t2;
    logic signed [V1W-1:0]  n_v1;
    logic signed [V2W-1:0]  n_v2;
    logic signed [WW-1:0]   n_w;

    assign s_sx      = {1'b0, r_s};
    assign s2_sx     = {1'b0, r_s2};
    assign n_scb     = r_s2 * r_s;
    assign n_scb_rnd = n_scb + (2*SW)'(32768);
    assign n_t1      = r_a1x3 * s_sx;
    assign n_t2      = r_a2x3 * s2_sx;
    assign n_v1      = r_a2 * s_sx;
    assign n_v2      = r_a3 * s2_sx;
    assign n_w       = r_a3 * s_sx;

    logic signed [A0W-1:0] r_c0;
    logic signed [A1W-1:0] r_c1;
    logic signed [A2W-1:0] r_c2;
    logic signed [A3W-1:0] r_c3;
    logic        [SW-1:0]  r_s3;
    logic signed [T1W-1:0] r_t1;
    logic signed [T2W-1:0] r_t2;
    logic signed [V1W-1:0] r_v1;
    logic signed [V2W-1:0] r_v2;
    logic signed [WW-1:0]  r_w;

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_c0 <= r_a0;
            r_c1 <= r_a1;
            r_c2 <= r_a2;
            r_c3 <= r_a3;
            r_s3 <= n_scb_rnd[SW+15:16];
            r_t1 <= n_t1;
            r_t2 <= n_t2;
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_w  <= n_w;
        end
    end

    assign o_c0 = r_c0;
    assign o_c1 = r_c1;
    assign o_c2 = r_c2;
    assign o_c3 = r_c3;
    assign o_s3 = r_s3;
    assign o_t1 = r_t1;
    assign o_t2 = r_t2;
    assign o_v1 = r_v1;
    assign o_v2 = r_v2;
    assign o_w  = r_w;

endmodule

`default_nettype wire

// ----- rtl/cbs_poly.sv -----
`default_nettype none

module cbs_poly (
    input  logic                              i_clk,
    input  cbs_pkg::t_adv                     i_adv,
    input  logic signed [cbs_pkg::A0W-1:0]    i_c0,
    input  logic signed [cbs_pkg::A1W-1:0]    i_c1,
    input  logic signed [cbs_pkg::A2W-1:0]    i_c2,
    input  logic signed [cbs_pkg::A3W-1:0]    i_c3,
    input  logic        [cbs_pkg::SW-1:0]     i_s3,
    input  logic signed [cbs_pkg::T1W-1:0]    i_t1,
    input  logic signed [cbs_pkg::T2W-1:0]    i_t2,
    input  logic signed [cbs_pkg::V1W-1:0]    i_v1,
    input  logic signed [cbs_pkg::V2W-1:0]    i_v2,
    input  logic signed [cbs_pkg::WW-1:0]     i_w,
    output logic signed [cbs_pkg::SUMW-1:0]   o_n,
    output logic                              o_dneg,
    output logic        [cbs_pkg::MAGW-1:0]   o_dmag,
    output logic                              o_eneg,
    output logic        [cbs_pkg::MAGW-1:0]   o_emag
);
    import cbs_pkg::*;

    // stage 3: last product, partial position sum, velocity and acceleration numerators
    logic signed [SW:0]     s3_sx;
    logic signed [P3W-1:0]  n_ps3;
    logic signed [SUMW-1:0] n_npart;
    logic signed [SUMW-1:0] n_d;
    logic signed [SUMW-1:0] n_e;

    assign s3_sx   = {1'b0, i_s3};
    assign n_ps3   = i_c3 * s3_sx;
    assign n_npart = (SUMW'(i_c0) <<< 16) + SUMW'(i_t1) + SUMW'(i_t2);
    assign n_d     = (SUMW'(i_c1) <<< 16) + (SUMW'(i_v1) <<< 1) + SUMW'(i_v2);
    assign n_e     = (SUMW'(i_c2) <<< 16) + SUMW'(i_w);

    logic signed [P3W-1:0]  r_ps3;
    logic signed [SUMW-1:0] r_npart;
    logic signed [SUMW-1:0] r_d;
    logic signed [SUMW-1:0] r_e;

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_ps3   <= n_ps3;
            r_npart <= n_npart;
            r_d     <= n_d;
            r_e     <= n_e;
        end
    end

    // stage 4: position numerator; round derivatives to Q16.16 as sign and magnitude
    // negative side folds the negate into the rounding add: ~x + 1 + half
    logic signed [SUMW-1:0] n_n;
    logic                   d_neg;
    logic                   e_neg;
    logic        [SUMW-1:0] n_dsum;
    logic        [SUMW-1:0] n_esum;

    assign n_n    = r_npart + SUMW'(r_ps3);
    assign d_neg  = r_d[SUMW-1];
    assign e_neg  = r_e[SUMW-1];
    assign n_dsum = (d_neg ? ~r_d : r_d) + (d_neg ? SUMW'(65537) : SUMW'(65536));
    assign n_esum = (e_neg ? ~r_e : r_e) + (e_neg ? SUMW'(32769) : SUMW'(32768));

    logic signed [SUMW-1:0] r_n;
    logic                   r_dneg;
    logic        [MAGW-1:0] r_dmag;
    logic                   r_eneg;
    logic        [MAGW-1:0] r_emag;

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_n    <= n_n;
            r_dneg <= d_neg;
            r_dmag <= n_dsum[MAGW+16:17];
            r_eneg <= e_neg;
            r_emag <= n_esum[MAGW+15:16];
        end
    end

    assign o_n    = r_n;
    assign o_dneg = r_dneg;
    assign o_dmag = r_dmag;
    assign o_eneg = r_eneg;
    assign o_emag = r_emag;

endmodule

`default_nettype wire

// ----- rtl/cbs_scale.sv -----
`default_nettype none

module cbs_scale (
    input  logic                              i_clk,
    input  cbs_pkg::t_adv                     i_adv,
    input  logic signed [cbs_pkg::SUMW-1:0]   i_n,
    input  logic                              i_dneg,
    input  logic        [cbs_pkg::MAGW-1:0]   i_dmag,
    input  logic                              i_eneg,
    input  logic        [cbs_pkg::MAGW-1:0]   i_emag,
    input  logic        [cbs_pkg::CFGW-1:0]   i_inv,
    input  logic        [cbs_pkg::INV2W-1:0]  i_inv2,
    output logic        [cbs_pkg::PW-1:0]     o_pos,
    output logic        [cbs_pkg::PW-1:0]     o_vel,
    output logic        [cbs_pkg::PW-1:0]     o_acc
);
    import cbs_pkg::*;

    localparam int                NUW      = SUMW - 17;
    localparam logic [NUW-1:0]    U_SAT    = NUW'(64'd6442450944);  // 3 * 2^31
    localparam logic [UW:0]       RECIP3   = (UW+1)'(64'd11453246123); // (2^35 + 1) / 3
    localparam logic [QW-1:0]     LIM_POS  = QW'(64'h7FFF_FFFF);
    localparam logic [QW-1:0]     LIM_NEG  = QW'(64'h8000_0000);
    localparam logic [PW-1:0]     SAT_MAX  = 32'h7FFF_FFFF;
    localparam logic [PW-1:0]     SAT_MIN  = 32'h8000_0000;

    function automatic logic [PW-1:0] sat_word(input logic neg, input logic [QW-1:0] mag);
        logic big;
        big = neg ? (mag > LIM_NEG) : (mag > LIM_POS);
        if (big) begin
            return neg ? SAT_MIN : SAT_MAX;
        end
        return neg ? (~mag[PW-1:0] + PW'(1)) : mag[PW-1:0];
    endfunction

    // stage 5: halve the rounded position numerator, scale derivatives
    logic              n_neg;
    logic [SUMW-1:0]   n_nsum;
    logic [NUW-1:0]    n_u;
    logic [VPW-1:0]    n_vp;
    logic [APW-1:0]    n_ap;

    assign n_neg  = i_n[SUMW-1];
    assign n_nsum = (n_neg ? ~i_n : i_n) + (n_neg ? SUMW'(196609) : SUMW'(196608));
    assign n_u    = n_nsum[SUMW-1:17];
    assign n_vp   = i_dmag * i_inv;
    assign n_ap   = i_emag * i_inv2;

    logic [UW-1:0]  r_pu;
    logic           r_psat5;
    logic           r_pneg5;
    logic [VPW-1:0] r_vp;
    logic           r_vneg5;
    logic [APW-1:0] r_ap;
    logic           r_aneg5;

    always_ff @(posedge i_clk) begin
        if (i_adv.s5) begin
            r_pu    <= n_u[UW-1:0];
            r_psat5 <= (n_u >= U_SAT);
            r_pneg5 <= n_neg;
            r_vp    <= n_vp;
            r_vneg5 <= i_dneg;
            r_ap    <= n_ap;
            r_aneg5 <= i_eneg;
        end
    end

    // stage 6: divide by three through the reciprocal, round the scaled derivatives
    logic [2*UW:0]  n_pprod;
    logic [VPW-1:0] n_vsum;
    logic [APW-1:0] n_asum;

    assign n_pprod = r_pu * RECIP3;
    assign n_vsum  = r_vp + VPW'(32768);
    assign n_asum  = r_ap + APW'(32768);

    logic [PQW-1:0]    r_pq;
    logic              r_psat6;
    logic              r_pneg6;
    logic [VPW-17:0]   r_vq;
    logic              r_vneg6;
    logic [QW-1:0]     r_aq;
    logic              r_aneg6;

    always_ff @(posedge i_clk) begin
        if (i_adv.s6) begin
            r_pq    <= n_pprod[PQW+34:35];
            r_psat6 <= r_psat5;
            r_pneg6 <= r_pneg5;
            r_vq    <= n_vsum[VPW-1:16];
            r_vneg6 <= r_vneg5;
            r_aq    <= n_asum[APW-1:16];
            r_aneg6 <= r_aneg5;
        end
    end

    // stage 7: apply sign and saturate into the output register
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_vel;
    logic [PW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_adv.s7) begin
            r_pos <= sat_word(r_pneg6, r_psat6 ? {QW{1'b1}} : QW'(r_pq));
            r_vel <= sat_word(r_vneg6, QW'(r_vq));
            r_acc <= sat_word(r_aneg6, r_aq);
        end
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ----- rtl/cubic_bspline_segment_eval.sv -----
// Uniform cubic B-spline segment evaluator, one axis.
//
// Input channel: i_in_valid / o_in_stall carry one word of four control
// points (signed Q16.16) and the local parameter s (Q1.16, clamped to 1.0).
// Output channel: o_out_valid / i_out_stall carry position, velocity and
// acceleration (signed Q16.16, saturated). A word moves on a rising edge
// where valid is high and stall is low.
// Configuration: i_cfg_we writes i_cfg_data into the inverse segment duration
// (unsigned Q9.16); its square is formed at the write. Write only while no
// word is in flight.
// Pipeline: seven register stages between the input and the output register.
// Throughput: one word per cycle while the output is not stalled, set by the
// seven-stage multiply/add pipeline.
// Stall: stages advance independently, so empty stages keep filling while
// the output waits; o_in_stall rises only once all seven stages hold a word.
// Reset: synchronous, active low; empties the pipeline and sets the inverse
// duration to 1.0.
`default_nettype none

module cubic_bspline_segment_eval (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic        [cbs_pkg::CFGW-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [cbs_pkg::PW-1:0]     i_ctrl_p0,
    input  logic signed [cbs_pkg::PW-1:0]     i_ctrl_p1,
    input  logic signed [cbs_pkg::PW-1:0]     i_ctrl_p2,
    input  logic signed [cbs_pkg::PW-1:0]     i_ctrl_p3,
    input  logic        [cbs_pkg::SW-1:0]     i_param_s,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [cbs_pkg::PW-1:0]     o_pos_out,
    output logic signed [cbs_pkg::PW-1:0]     o_vel_out,
    output logic signed [cbs_pkg::PW-1:0]     o_acc_out
);
    import cbs_pkg::*;

    // configuration
    logic [CFGW-1:0]   r_inv;
    logic [INV2W-1:0]  r_inv2;
    logic [2*CFGW-1:0] n_isq;
    logic [2*CFGW-1:0] n_isq_rnd;

    assign n_isq     = i_cfg_data * i_cfg_data;
    assign n_isq_rnd = n_isq + (2*CFGW)'(32768);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= INV_RST;
            r_inv2 <= INV2_RST;
        end else if (i_cfg_we) begin
            r_inv  <= i_cfg_data;
            r_inv2 <= n_isq_rnd[INV2W+15:16];
        end
    end

    // stage valids and advance enables; a stage moves when empty or when its
    // successor moves
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] adv_en;
    logic [LAT-1:0] vld_in;
    t_adv           adv;

    always_comb begin
        adv_en[LAT-1] = !r_vld[LAT-1] || !i_out_stall;
        for (int k = LAT - 2; k >= 0; k--) begin
            adv_en[k] = !r_vld[k] || adv_en[k+1];
        end
    end

    assign vld_in = {r_vld[LAT-2:0], i_in_valid};
    assign adv    = t_adv'(adv_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < LAT; k++) begin
                if (adv_en[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    assign o_in_stall  = !adv_en[0];
    assign o_out_valid = r_vld[LAT-1];

    // datapath
    logic signed [A0W-1:0]  c0;
    logic signed [A1W-1:0]  c1;
    logic signed [A2W-1:0]  c2;
    logic signed [A3W-1:0]  c3;
    logic        [SW-1:0]   s3;
    logic signed [T1W-1:0]  t1;
    logic signed [T2W-1:0]  t2;
    logic signed [V1W-1:0]  v1;
    logic signed [V2W-1:0]  v2;
    logic signed [WW-1:0]   w;
    logic signed [SUMW-1:0] pn;
    logic                   dneg;
    logic        [MAGW-1:0] dmag;
    logic                   eneg;
    logic        [MAGW-1:0] emag;
    logic        [PW-1:0]   pos_w;
    logic        [PW-1:0]   vel_w;
    logic        [PW-1:0]   acc_w;

    cbs_basis u_basis (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_ctrl_p0 (i_ctrl_p0),
        .i_ctrl_p1 (i_ctrl_p1),
        .i_ctrl_p2 (i_ctrl_p2),
        .i_ctrl_p3 (i_ctrl_p3),
        .i_param_s (i_param_s),
        .o_c0      (c0),
        .o_c1      (c1),
        .o_c2      (c2),
        .o_c3      (c3),
        .o_s3      (s3),
        .o_t1      (t1),
        .o_t2      (t2),
        .o_v1      (v1),
        .o_v2      (v2),
        .o_w       (w)
    );

    cbs_poly u_poly (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_c0   (c0),
        .i_c1   (c1),
        .i_c2   (c2),
        .i_c3   (c3),
        .i_s3   (s3),
        .i_t1   (t1),
        .i_t2   (t2),
        .i_v1   (v1),
        .i_v2   (v2),
        .i_w    (w),
        .o_n    (pn),
        .o_dneg (dneg),
        .o_dmag (dmag),
        .o_eneg (eneg),
        .o_emag (emag)
    );

    cbs_scale u_scale (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_n    (pn),
        .i_dneg (dneg),
        .i_dmag (dmag),
        .i_eneg (eneg),
        .i_emag (emag),
        .i_inv  (r_inv),
        .i_inv2 (r_inv2),
        .o_pos  (pos_w),
        .o_vel  (vel_w),
        .o_acc  (acc_w)
    );

    assign o_pos_out = pos_w;
    assign o_vel_out = vel_w;
    assign o_acc_out = acc_w;

    // input backs up only when every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // input backs up only behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> i_out_stall)
        else $error("input stalled while output drains");

    // a held middle stage keeps its word
    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !adv_en[3]) |=> r_vld[3])
        else $error("held stage lost its word");

endmodule

`default_nettype wire
